// ===== sv/dah_pkg.sv =====
// Shared constants, types and the cosine table builder for the Doppler addback histogrammer.
// No dependencies; imported by dah_cos_rom and doppler_addback_histogrammer_core.
package dah_pkg;

    localparam int NUM_BINS    = 1600;
    localparam int ANGLE_STEPS = 4096;

    // field widths
    localparam int ENERGY_W = 20;
    localparam int THETA_W  = 12;
    localparam int IDX_W    = 12;
    localparam int SUM_W    = 24;
    localparam int COUNT_W  = 32;
    localparam int BETA_W   = 16;
    localparam int GAMMA_W  = 24;
    localparam int SCALE_W  = 32;

    // derived sizes
    localparam int BIN_W       = $clog2(NUM_BINS);
    localparam int COS_ENTRIES = ANGLE_STEPS / 2 + 1;
    localparam int COS_AW      = $clog2(COS_ENTRIES);
    localparam int K_W         = $clog2(ANGLE_STEPS + 1);
    localparam int COS_W       = 17;   // |cos| in Q16, 0..65536

    // register indexes
    localparam logic [1:0] REG_BETA  = 2'd0;
    localparam logic [1:0] REG_GAMMA = 2'd1;
    localparam logic [1:0] REG_SCALE = 2'd2;

    localparam logic [BETA_W-1:0]  BETA_RST  = 16'd52429;
    localparam logic [GAMMA_W-1:0] GAMMA_RST = 24'd109227;
    localparam logic [SCALE_W-1:0] SCALE_RST = 32'd10783399;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    // Taylor series divisors (2n-1)*2n for n = 1..8
    localparam int unsigned SERIES_DIV [1:8] = '{2, 12, 30, 56, 90, 132, 182, 240};

    typedef logic [COS_W-1:0] t_cos_tab [COS_ENTRIES];

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COS,
        ST_BETA,
        ST_FACT,
        ST_PLO,
        ST_PHI,
        ST_CORR,
        ST_ACC,
        ST_BIN,
        ST_LOOK,
        ST_INC,
        ST_READ,
        ST_OUT
    } t_state;

    // cos(pi*k/ANGLE_STEPS) for the first quarter turn, Q16; built at elaboration
    function automatic t_cos_tab f_cos_table();
        t_cos_tab           tab;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] acc;
        for (int k = 0; k < COS_ENTRIES; k++) begin
            x    = (PI_Q30 * 64'(k) + 64'(ANGLE_STEPS / 2)) / 64'(ANGLE_STEPS);
            x2   = (x * x) >> 30;
            term = 64'd1 << 30;
            acc  = $signed(term);
            for (int n = 1; n <= 8; n++) begin
                term = ((term * x2) >> 30) / 64'(SERIES_DIV[n]);
                if ((n & 1) == 1) acc = acc - $signed(term);
                else              acc = acc + $signed(term);
            end
            if (acc < 64'sd0)          acc = 64'sd0;
            if (acc > 64'sd1073741824) acc = 64'sd1073741824;
            tab[k] = COS_W'((acc + 64'sd8192) >>> 14);
        end
        return tab;
    endfunction

endpackage

// ===== sv/dah_cos_rom.sv =====
// Cosine magnitude ROM, first quarter turn, registered read.
// Depends on dah_pkg for the table builder and sizes.
module dah_cos_rom (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [dah_pkg::COS_AW-1:0] i_addr,
    output logic [dah_pkg::COS_W-1:0]  o_data
);
    import dah_pkg::*;

    localparam t_cos_tab COS_TAB = f_cos_table();

    logic [COS_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= COS_TAB[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

// ===== sv/dah_hist_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module dah_hist_ram #(
    parameter int DEPTH = 1600,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/doppler_addback_histogrammer_core.sv =====
// Doppler addback histogrammer top level: sequencer, arithmetic and APB registers.
// Depends on dah_pkg, dah_cos_rom and dah_hist_ram.
//
// One word in, one word out. An add word Doppler-corrects its cluster energy as
// gamma*(1-beta*cos theta)*E, folds it into the saturating event sum, and on the
// last cluster of an event (sum nonzero) bins sum*bin_scale into the histogram
// RAM, or bumps the overflow counter when the bin lies past the end. A read word
// returns one bin count (or the overflow count for an index at or past the bin
// count) and leaves all state alone. A new input word is taken only after the
// previous word has gone through all its states and its result has been loaded
// into the output register. The add path is a chain of states that hold one
// cosine ROM read and one multiply each at most (E*gamma beside the ROM read,
// then beta*cos, two partial products of the 62-bit energy product, and
// sum*scale), followed by a read-modify-write of one histogram RAM entry.
// After reset the histogram RAM is zeroed by a clearing pass over all NUM_BINS
// (1600) entries, one entry per cycle, during which no input word is taken;
// APB writes are taken at any time. The result sits in an output register, so
// the next word is taken while the previous result waits.
module doppler_addback_histogrammer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [19:0] cluster_energy_kev, [31:20] theta_code, [43:32] read_index, [47:44] zero
    input  logic [47:0] i_s_axis_tdata,
    // [0] action
    input  logic [0:0]  i_s_axis_tuser,
    // last_of_event
    input  logic        i_s_axis_tlast,

    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [31:0] bin_count, [55:32] event_energy_kev, [67:56] bin_index, [71:68] zero
    output logic [71:0] o_m_axis_tdata,
    // [0] filled, [1] overflowed
    output logic [1:0]  o_m_axis_tuser,

    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dah_pkg::*;

    localparam int TK_W     = (K_W > THETA_W) ? K_W : THETA_W;
    localparam int EG_W     = ENERGY_W + GAMMA_W;     // E*gamma
    localparam int PP_SPLIT = EG_W / 2;               // low slice of E*gamma
    localparam int BMAG_W   = BETA_W + COS_W;         // beta*|cos|
    localparam int F16_W    = 18;                     // factor in Q16, < 2^17 + 1
    localparam int PLO_W    = PP_SPLIT + F16_W;
    localparam int PHI_W    = (EG_W - PP_SPLIT) + F16_W;
    localparam int PROD_W   = EG_W + F16_W;
    localparam int F32_W    = 34;
    localparam int BPROD_W  = SUM_W + SCALE_W;

    // ---------------- configuration registers ----------------
    logic [BETA_W-1:0]  r_beta;
    logic [GAMMA_W-1:0] r_gamma;
    logic [SCALE_W-1:0] r_scale;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beta  <= BETA_RST;
            r_gamma <= GAMMA_RST;
            r_scale <= SCALE_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_BETA:  r_beta  <= pwdata[BETA_W-1:0];
                REG_GAMMA: r_gamma <= pwdata[GAMMA_W-1:0];
                REG_SCALE: r_scale <= pwdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_BETA:  prdata = 32'(r_beta);
            REG_GAMMA: prdata = 32'(r_gamma);
            REG_SCALE: prdata = r_scale;
            default:   prdata = '0;
        endcase
    end

    // ---------------- input field split ----------------
    logic                in_action;
    logic [ENERGY_W-1:0] in_energy;
    logic [THETA_W-1:0]  in_theta;
    logic [IDX_W-1:0]    in_ridx;

    assign in_action = i_s_axis_tuser[0];
    assign in_energy = i_s_axis_tdata[19:0];
    assign in_theta  = i_s_axis_tdata[31:20];
    assign in_ridx   = i_s_axis_tdata[43:32];

    // angle code: saturate, then fold the second quarter turn onto the first
    logic [TK_W-1:0]   theta_ext;
    logic [K_W-1:0]    k_sat;
    logic              k_upper;
    logic [COS_AW-1:0] cos_addr;

    always_comb begin
        theta_ext = TK_W'(in_theta);
        if (theta_ext >= TK_W'(ANGLE_STEPS)) begin
            k_sat = K_W'(ANGLE_STEPS - 1);
        end else begin
            k_sat = K_W'(theta_ext);
        end
        k_upper = {k_sat, 1'b0} > (K_W + 1)'(ANGLE_STEPS);
        if (k_upper) begin
            cos_addr = COS_AW'(K_W'(ANGLE_STEPS) - k_sat);
        end else begin
            cos_addr = COS_AW'(k_sat);
        end
    end

    // ---------------- state ----------------
    t_state r_state, n_state;

    logic [BIN_W-1:0]    r_clr_addr;
    logic [SUM_W-1:0]    r_sum;
    logic [COUNT_W-1:0]  r_ovf_cnt;

    // per-word work registers
    logic                r_action;
    logic                r_last;
    logic [ENERGY_W-1:0] r_energy;
    logic [COS_AW-1:0]   r_cos_addr;
    logic                r_neg;
    logic                r_rd_in_range;
    logic [EG_W-1:0]     r_eg;
    logic [BMAG_W-1:0]   r_bmag;
    logic [F16_W-1:0]    r_f16;
    logic [PLO_W-1:0]    r_plo;
    logic [PHI_W-1:0]    r_phi;
    logic [SUM_W-1:0]    r_corr;
    logic [SCALE_W-1:0]  r_binv;

    // result being built
    logic [COUNT_W-1:0]  r_count;
    logic [SUM_W-1:0]    r_ev;
    logic [IDX_W-1:0]    r_bin_out;
    logic                r_filled;
    logic                r_ovf;

    // output register
    logic                r_m_valid;
    logic [71:0]         r_m_tdata;
    logic [1:0]          r_m_tuser;

    // ---------------- ROM and RAM ----------------
    logic                rom_en;
    logic [COS_W-1:0]    rom_data;
    logic                ram_we;
    logic [BIN_W-1:0]    ram_waddr;
    logic [COUNT_W-1:0]  ram_wdata;
    logic                ram_re;
    logic [BIN_W-1:0]    ram_raddr;
    logic [COUNT_W-1:0]  ram_rdata;

    dah_cos_rom u_cos_rom (
        .i_clk  (i_clk),
        .i_en   (rom_en),
        .i_addr (r_cos_addr),
        .o_data (rom_data)
    );

    dah_hist_ram #(
        .DEPTH (NUM_BINS),
        .WIDTH (COUNT_W)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ---------------- sequencer ----------------
    logic in_accept;
    logic out_load;
    logic bin_in_range;

    assign in_accept    = i_s_axis_tvalid && o_s_axis_tready;
    assign bin_in_range = r_binv < SCALE_W'(NUM_BINS);

    always_comb begin
        n_state         = r_state;
        o_s_axis_tready = 1'b0;
        rom_en          = 1'b0;
        ram_re          = 1'b0;
        ram_raddr       = r_binv[BIN_W-1:0];
        ram_we          = 1'b0;
        ram_waddr       = r_binv[BIN_W-1:0];
        ram_wdata       = ram_rdata + COUNT_W'(1);
        out_load        = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
                if (r_clr_addr == BIN_W'(NUM_BINS - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                ram_re          = i_s_axis_tvalid && in_action;
                ram_raddr       = in_ridx[BIN_W-1:0];
                if (i_s_axis_tvalid) n_state = in_action ? ST_READ : ST_COS;
            end
            ST_COS: begin
                rom_en  = 1'b1;
                n_state = ST_BETA;
            end
            ST_BETA: n_state = ST_FACT;
            ST_FACT: n_state = ST_PLO;
            ST_PLO:  n_state = ST_PHI;
            ST_PHI:  n_state = ST_CORR;
            ST_CORR: n_state = ST_ACC;
            ST_ACC:  n_state = r_last ? ST_BIN : ST_OUT;
            ST_BIN:  n_state = ST_LOOK;
            ST_LOOK: begin
                if (r_ev != '0 && bin_in_range) begin
                    ram_re  = 1'b1;
                    n_state = ST_INC;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_INC: begin
                ram_we  = 1'b1;
                n_state = ST_OUT;
            end
            ST_READ: n_state = ST_OUT;
            ST_OUT: begin
                if (!r_m_valid || i_m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- datapath ----------------
    logic [F32_W-1:0]  f32;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-33:0] corr_full;
    logic [SUM_W:0]    sum_wide;
    logic [SUM_W-1:0]  sum_next;
    logic [BPROD_W-1:0] bin_prod;

    always_comb begin
        // factor 2^32 - beta*cos, cos sign carried separately
        if (r_neg) f32 = F32_W'(64'h1_0000_0000) + F32_W'(r_bmag);
        else       f32 = F32_W'(64'h1_0000_0000) - F32_W'(r_bmag);
        prod      = PROD_W'({r_phi, {PP_SPLIT{1'b0}}}) + PROD_W'(r_plo)
                  + PROD_W'(64'h8000_0000);
        corr_full = prod[PROD_W-1:32];
        sum_wide  = {1'b0, r_sum} + {1'b0, r_corr};
        sum_next  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
        bin_prod  = r_ev * r_scale;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_sum      <= '0;
            r_ovf_cnt  <= '0;
        end else begin
            if (r_state == ST_CLEAR) r_clr_addr <= r_clr_addr + BIN_W'(1);
            if (r_state == ST_ACC) r_sum <= r_last ? '0 : sum_next;
            if (r_state == ST_LOOK && r_ev != '0 && !bin_in_range) begin
                r_ovf_cnt <= r_ovf_cnt + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    r_action      <= in_action;
                    r_last        <= i_s_axis_tlast;
                    r_energy      <= in_energy;
                    r_cos_addr    <= cos_addr;
                    r_neg         <= k_upper;
                    r_rd_in_range <= {1'b0, in_ridx} < (IDX_W + 1)'(NUM_BINS);
                    r_count       <= '0;
                    r_bin_out     <= '0;
                    r_filled      <= 1'b0;
                    r_ovf         <= 1'b0;
                end
            end
            ST_COS:  r_eg   <= r_energy * r_gamma;
            ST_BETA: r_bmag <= r_beta * rom_data;
            ST_FACT: r_f16  <= f32[F32_W-1:16] + F16_W'(f32[15]);
            ST_PLO:  r_plo  <= r_eg[PP_SPLIT-1:0] * r_f16;
            ST_PHI:  r_phi  <= r_eg[EG_W-1:PP_SPLIT] * r_f16;
            ST_CORR: begin
                if (corr_full[PROD_W-33:SUM_W] != '0) r_corr <= {SUM_W{1'b1}};
                else                                  r_corr <= corr_full[SUM_W-1:0];
            end
            ST_ACC:  r_ev   <= sum_next;
            ST_BIN:  r_binv <= bin_prod[BPROD_W-1:24];
            ST_LOOK: begin
                if (r_ev != '0 && !bin_in_range) r_ovf <= 1'b1;
            end
            ST_INC: begin
                r_filled  <= 1'b1;
                r_bin_out <= IDX_W'(r_binv[BIN_W-1:0]);
            end
            ST_READ: begin
                r_count <= r_rd_in_range ? ram_rdata : r_ovf_cnt;
                r_ev    <= r_sum;
            end
            default: ;
        endcase
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_tdata <= {4'b0, r_bin_out, r_ev, r_count};
            r_m_tuser <= {r_ovf, r_filled};
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_tdata;
    assign o_m_axis_tuser  = r_m_tuser;

    // ---------------- assertions ----------------
    a_fill_ovf_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tuser[0] && o_m_axis_tuser[1]))
        else $error("filled and overflowed both set");

    a_bin_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |-> (o_m_axis_tdata[67:56] == '0))
        else $error("bin_index nonzero without a fill");

    a_sum_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && r_last && !r_action) |-> (r_sum == '0))
        else $error("addback sum not cleared at event close");

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_s_axis_tready)
        else $error("input taken during clearing pass");

endmodule

// ===== tb/doppler_addback_histogrammer_core_tb.sv =====
// Self-checking testbench for doppler_addback_histogrammer_core: stream words in,
// results checked against an in-bench model of the correction, addback and histogram.
// Depends on dah_pkg and the core RTL only.
module doppler_addback_histogrammer_core_tb;
    import dah_pkg::*;

    // Longest legal quiet stretch is the RAM clearing pass or the long receiver
    // hold-off; this limit is several times both.
    localparam int          WATCHDOG_LIMIT  = 5000;
    localparam int          HOLD_OFF_CYCLES = 400;
    localparam int          DRAIN_CYCLES    = 24;
    localparam int          MAX_PRINTS      = 30;
    localparam logic [23:0] SUM_CEIL        = 24'hFFFFFF;

    typedef enum logic {
        ACT_ADD  = 1'b0,
        ACT_READ = 1'b1
    } t_action;

    typedef struct packed {
        t_action     action;
        logic [19:0] energy_kev;
        logic [11:0] theta_code;
        logic        closes_event;
        logic [11:0] read_index;
    } t_cluster_word;

    typedef struct packed {
        logic [31:0] bin_count;
        logic [23:0] event_kev;
        logic [11:0] bin_index;
        logic        filled;
        logic        overflowed;
    } t_hist_result;

    // ---------------------------------------------------------------- DUT ports
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    // [19:0] cluster_energy_kev, [31:20] theta_code, [43:32] read_index, [47:44] zero
    logic [47:0] i_s_axis_tdata  = '0;
    // [0] action
    logic [0:0]  i_s_axis_tuser  = '0;
    logic        i_s_axis_tlast  = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // [31:0] bin_count, [55:32] event_energy_kev, [67:56] bin_index, [71:68] zero
    logic [71:0] o_m_axis_tdata;
    // [0] filled, [1] overflowed
    logic [1:0]  o_m_axis_tuser;
    logic        psel            = 1'b0;
    logic        penable         = 1'b0;
    logic        pwrite          = 1'b0;
    logic [3:0]  paddr           = '0;
    logic [31:0] pwdata          = '0;
    logic [31:0] prdata;
    logic        pready;

    // ---------------------------------------------------------------- model state
    logic [16:0]  cos_q16 [0:ANGLE_STEPS/2];   // |cos| for the first quarter turn, Q16
    logic [15:0]  beta_q16;
    logic [23:0]  gamma_q16;
    logic [31:0]  scale_q24;
    logic [23:0]  event_sum;
    logic [31:0]  bin_counts [NUM_BINS];
    logic [31:0]  overflow_total;
    logic [11:0]  last_filled_bin;
    t_hist_result pending_results [$];

    // ---------------------------------------------------------------- bookkeeping
    int error_count       = 0;
    int words_sent        = 0;
    int reads_sent        = 0;
    int results_checked   = 0;
    int events_filled     = 0;
    int events_overflowed = 0;
    int settings_applied  = 1;   // reset values count as the first setting

    // idling knobs
    int          tx_max_gap   = 0;
    int          burst_left   = 0;
    logic [15:0] rx_pattern   = 16'hFFFF;
    int          rx_phase     = 0;
    int          hold_request = 0;
    int          hold_left    = 0;
    int          stall_cycles = 0;

    doppler_addback_histogrammer_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #2 i_clk = ~i_clk;

    // ================================================================ model
    // Q30 Taylor series for cos over [0, pi/2], clamped, rounded to Q16.
    task automatic build_cos_table();
        logic [63:0] ang;
        logic [63:0] ang_sq;
        logic [63:0] term;
        longint      acc;
        for (int k = 0; k <= ANGLE_STEPS / 2; k++) begin
            ang    = (64'd3373259426 * 64'(k) + 64'(ANGLE_STEPS / 2)) / 64'(ANGLE_STEPS);
            ang_sq = (ang * ang) >> 30;
            term   = 64'd1 << 30;
            acc    = longint'(term);
            for (int n = 1; n <= 8; n++) begin
                term = ((term * ang_sq) >> 30) / 64'((2 * n - 1) * (2 * n));
                if (n % 2 == 1) acc = acc - longint'(term);
                else            acc = acc + longint'(term);
            end
            if (acc < 0)             acc = 0;
            if (acc > (64'sd1 <<< 30)) acc = 64'sd1 <<< 30;
            cos_q16[k] = 17'((acc + 64'sd8192) >>> 14);
        end
    endtask

    task automatic model_reset();
        beta_q16        = BETA_RST;
        gamma_q16       = GAMMA_RST;
        scale_q24       = SCALE_RST;
        event_sum       = '0;
        overflow_total  = '0;
        last_filled_bin = '0;
        for (int b = 0; b < NUM_BINS; b++) bin_counts[b] = '0;
    endtask

    // gamma * (1 - beta*cos) * E, rounded, saturated to 24 bits
    function automatic logic [23:0] corrected_kev(input logic [19:0] e, input logic [11:0] th);
        int          k;
        longint      cosv;
        longint      factor32;
        logic [63:0] f16;
        logic [63:0] prod;
        logic [63:0] kev;
        k = int'(th);
        if (2 * k <= ANGLE_STEPS) cosv = longint'(cos_q16[th]);
        else                      cosv = -longint'(cos_q16[12'(ANGLE_STEPS - k)]);
        factor32 = (64'sd1 <<< 32) - longint'(beta_q16) * cosv;
        f16  = (64'(factor32) + 64'd32768) >> 16;
        prod = 64'(e) * 64'(gamma_q16) * f16;
        kev  = (prod + (64'd1 << 31)) >> 32;
        return (kev > 64'(SUM_CEIL)) ? SUM_CEIL : kev[23:0];
    endfunction

    // Advances the model by one accepted word and returns the result it owes.
    function automatic t_hist_result histogram_step(input t_cluster_word w);
        t_hist_result r;
        logic [23:0]  kev;
        logic [24:0]  total;
        logic [55:0]  scaled;
        logic [31:0]  bin;
        r = '0;
        if (w.action == ACT_READ) begin
            r.bin_count = (w.read_index < NUM_BINS) ? bin_counts[w.read_index[10:0]]
                                                    : overflow_total;
            r.event_kev = event_sum;
        end else begin
            kev = corrected_kev(w.energy_kev, w.theta_code);
            if (kev != '0) begin
                total     = {1'b0, event_sum} + {1'b0, kev};
                event_sum = (total > {1'b0, SUM_CEIL}) ? SUM_CEIL : total[23:0];
            end
            r.event_kev = event_sum;
            if (w.closes_event) begin
                if (event_sum != '0) begin
                    scaled = 56'(event_sum) * 56'(scale_q24);
                    bin    = scaled[55:24];
                    if (bin < NUM_BINS) begin
                        bin_counts[bin[10:0]] = bin_counts[bin[10:0]] + 32'd1;
                        r.bin_index     = bin[11:0];
                        r.filled        = 1'b1;
                        last_filled_bin = bin[11:0];
                        events_filled++;
                    end else begin
                        overflow_total = overflow_total + 32'd1;
                        r.overflowed   = 1'b1;
                        events_overflowed++;
                    end
                end
                event_sum = '0;
            end
        end
        return r;
    endfunction

    // ================================================================ word builders
    function automatic t_cluster_word make_cluster(input logic [19:0] e, input logic [11:0] th,
                                                   input logic closes);
        t_cluster_word w;
        w.action       = ACT_ADD;
        w.energy_kev   = e;
        w.theta_code   = th;
        w.closes_event = closes;
        w.read_index   = 12'($urandom);   // ignored on adds, toggled anyway
        return w;
    endfunction

    // read word; cluster fields are junk the block must ignore
    function automatic t_cluster_word make_read(input logic [11:0] idx);
        t_cluster_word w;
        w.action       = ACT_READ;
        w.energy_kev   = 20'($urandom);
        w.theta_code   = 12'($urandom);
        w.closes_event = 1'($urandom);
        w.read_index   = idx;
        return w;
    endfunction

    // mostly bins that land inside the histogram, some tiny, some full range
    function automatic logic [19:0] pick_energy();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 15)      return 20'($urandom_range(0, 7));
        else if (roll < 25) return 20'($urandom);
        else                return 20'($urandom_range(1, 1500));
    endfunction

    // ================================================================ drivers
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h (result %0d)",
                     $time, what, got, want, results_checked);
    endtask

    // Entered and left just after a falling edge. Gaps come between bursts.
    task automatic send_word(input t_cluster_word w);
        int gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, tx_max_gap);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                i_s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_s_axis_tdata  = {4'b0, w.read_index, w.theta_code, w.energy_kev};
        i_s_axis_tuser  = w.action;
        i_s_axis_tlast  = w.closes_event;
        i_s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_results.push_back(histogram_step(w));
        words_sent++;
        if (w.action == ACT_READ) reads_sent++;
        @(negedge i_clk);
    endtask

    task automatic stop_sending();
        i_s_axis_tvalid = 1'b0;
        burst_left      = 0;
    endtask

    task automatic wait_idle();
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_idling(input int max_gap, input logic [15:0] pattern);
        tx_max_gap = max_gap;
        rx_pattern = pattern;
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_BETA:  beta_q16  = value[15:0];
            REG_GAMMA: gamma_q16 = value[23:0];
            REG_SCALE: scale_q24 = value;
            default: ;
        endcase
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // read back one register and compare with the model copy
    task automatic apb_check(input logic [1:0] idx);
        logic [31:0] want;
        case (idx)
            REG_BETA:  want = 32'(beta_q16);
            REG_GAMMA: want = 32'(gamma_q16);
            default:   want = scale_q24;
        endcase
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) report_mismatch($sformatf("register %0d readback", idx),
                                             64'(prdata), 64'(want));
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // only called with the block drained
    task automatic set_config(input logic [15:0] beta, input logic [23:0] gamma,
                              input logic [31:0] scale);
        wait_idle();
        apb_write(REG_BETA, 32'(beta));
        apb_write(REG_GAMMA, 32'(gamma));
        apb_write(REG_SCALE, scale);
        apb_check(REG_BETA);
        apb_check(REG_GAMMA);
        apb_check(REG_SCALE);
        settings_applied++;
    endtask

    // Mostly whole events of 1..5 clusters; reads and stray clusters mixed in.
    task automatic run_traffic(input int n_words);
        int            sent;
        int            clusters;
        int unsigned   roll;
        int unsigned   pick;
        t_cluster_word w;
        sent = 0;
        while (sent < n_words) begin
            roll = $urandom_range(0, 99);
            if (roll < 12) begin
                pick = $urandom_range(0, 2);
                if (pick == 0)      w = make_read(last_filled_bin);
                else if (pick == 1) w = make_read(12'($urandom_range(0, NUM_BINS - 1)));
                else                w = make_read(12'($urandom));
                send_word(w);
                sent++;
            end else if (roll < 20) begin
                // stray cluster: any energy, random close flag
                send_word(make_cluster(20'($urandom), 12'($urandom), 1'($urandom)));
                sent++;
            end else begin
                clusters = $urandom_range(1, 5);
                for (int c = 0; c < clusters; c++)
                    send_word(make_cluster(pick_energy(), 12'($urandom),
                                           c == clusters - 1));
                sent += clusters;
            end
        end
        stop_sending();
    endtask

    // ================================================================ tests
    // registers come up at their reset values; readable during the clearing pass
    task automatic test_register_defaults();
        apb_check(REG_BETA);
        apb_check(REG_GAMMA);
        apb_check(REG_SCALE);
    endtask

    // corner words under the reset setting
    task automatic test_directed_cases();
        set_idling(2, 16'hEEEF);
        send_word(make_read(12'd0));                    // empty histogram
        send_word(make_read(12'hFFF));                  // overflow counter, still zero
        send_word(make_cluster(20'd1000, 12'd0, 1'b1)); // forward angle, one-cluster event
        send_word(make_read(last_filled_bin));
        send_word(make_cluster(20'd1, 12'd0, 1'b0));    // corrects to zero, not added
        send_word(make_cluster(20'd0, 12'd2048, 1'b1)); // event closes with zero sum
        // full-scale backward clusters: sum pins at the ceiling, event lands past the end
        for (int i = 0; i < 6; i++)
            send_word(make_cluster(20'hFFFFF, 12'hFFF, i == 5));
        send_word(make_read(12'(NUM_BINS)));
        send_word(make_cluster(20'd300, 12'd1024, 1'b0));
        send_word(make_cluster(20'd500, 12'd3072, 1'b0));
        send_word(make_read(12'h800));                  // read mid-event shows running sum
        send_word(make_cluster(20'd200, 12'd2048, 1'b1));
        send_word(make_read(last_filled_bin));
        send_word(make_read(12'(NUM_BINS - 1)));
        send_word(make_cluster(20'd2000, 12'd1, 1'b1));
        send_word(make_cluster(20'd4000, 12'd4095, 1'b1));
        send_word(make_read(12'(NUM_BINS)));
        stop_sending();
    endtask

    // random traffic under the reset setting and four others, extremes included
    task automatic test_config_sweep();
        set_idling(6, 16'($urandom) | 16'h0101);
        run_traffic(125);
        // unity correction, one bin per keV; no idling on either side
        set_config(16'd0, 24'd65536, 32'h0100_0000);
        set_idling(0, 16'hFFFF);
        run_traffic(110);
        // strongest correction, everything into bin zero
        set_config(16'hFFFF, 24'hFFFFFF, 32'd0);
        set_idling(10, 16'($urandom) | 16'h0101);
        run_traffic(110);
        // widest scale: nearly every event overflows
        set_config(16'($urandom), 24'($urandom_range(65536, 16777215)), 32'hFFFF_FFFF);
        set_idling(4, 16'($urandom) | 16'h1111);
        run_traffic(110);
        set_config(16'd32768, 24'd75674, 32'($urandom_range(1 << 22, 1 << 25)));
        set_idling(3, 16'($urandom) | 16'h0303);
        run_traffic(110);
    endtask

    // receiver stalls for a long stretch while words keep coming back to back
    task automatic test_output_backpressure();
        wait_idle();
        set_idling(0, 16'hFFFF);
        hold_request = HOLD_OFF_CYCLES;
        run_traffic(40);
        set_idling(5, 16'($urandom) | 16'h0101);
    endtask

    // ================================================================ processes
    // receiver: long hold-off on request, else a rotating stall pattern
    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            rx_phase = (rx_phase + 1) % 16;
            i_m_axis_tready <= rx_pattern[rx_phase];
        end
    end

    // result checker: every accepted result against the oldest expectation
    always @(posedge i_clk) begin : check_result
        t_hist_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", o_m_axis_tdata[63:0], '0);
            end else begin
                want = pending_results.pop_front();
                if (o_m_axis_tdata[31:0] !== want.bin_count)
                    report_mismatch("bin_count", 64'(o_m_axis_tdata[31:0]), 64'(want.bin_count));
                if (o_m_axis_tdata[55:32] !== want.event_kev)
                    report_mismatch("event_energy_kev", 64'(o_m_axis_tdata[55:32]),
                                    64'(want.event_kev));
                if (o_m_axis_tdata[67:56] !== want.bin_index)
                    report_mismatch("bin_index", 64'(o_m_axis_tdata[67:56]), 64'(want.bin_index));
                if (o_m_axis_tdata[71:68] !== 4'b0)
                    report_mismatch("tdata padding", 64'(o_m_axis_tdata[71:68]), '0);
                if (o_m_axis_tuser[0] !== want.filled)
                    report_mismatch("filled", 64'(o_m_axis_tuser[0]), 64'(want.filled));
                if (o_m_axis_tuser[1] !== want.overflowed)
                    report_mismatch("overflowed", 64'(o_m_axis_tuser[1]), 64'(want.overflowed));
                results_checked++;
            end
        end
    end

    // watchdog: quiet cycles on both streams
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("doppler_addback_histogrammer_core_tb: FAIL");
            $finish;
        end
    end

    initial begin
        build_cos_table();
        model_reset();
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_register_defaults();
        test_directed_cases();
        test_config_sweep();
        test_output_backpressure();

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Sent %0d words (%0d reads) across %0d register settings, checked %0d results.",
                 words_sent, reads_sent, settings_applied, results_checked);
        $display("Events binned: %0d, past the last bin: %0d, receiver hold-off of %0d cycles.",
                 events_filled, events_overflowed, HOLD_OFF_CYCLES);
        if (error_count == 0) begin
            $display("doppler_addback_histogrammer_core_tb: PASS");
        end else begin
            $display("doppler_addback_histogrammer_core_tb: FAIL");
        end
        $finish;
    end

endmodule
